/* rtl/additive_partial_generator_unit_macros.svh */
// ----------------------------------------------------------------------------
// additive partial generator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_PARTIAL_GENERATOR_UNIT_MACROS_SVH
`define ADDITIVE_PARTIAL_GENERATOR_UNIT_MACROS_SVH

// condition now implies consequence next cycle
`define APG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("apg port check failed");

// condition implies consequence in the same cycle
`define APG_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("apg port check failed");

`endif

/* rtl/apg_pkg.sv */
// ----------------------------------------------------------------------------
// apg_pkg
// constants, tables and register codes of the additive partial generator
// ----------------------------------------------------------------------------
package apg_pkg;

  localparam int MAX_PARTIALS = 64;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 18;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STIFF = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 4'd7;

  localparam logic [1:0] MODE_HARMONIC = 2'd0;
  localparam logic [1:0] MODE_BAR      = 2'd2;

  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [30:0] ONE_Q30    = 31'h40000000;
  localparam logic [31:0] FLOOR_Q30  = 32'd1073742;
  localparam logic [31:0] DB20_LOG2  = 32'd394566;
  localparam logic [31:0] RECIP_25   = 32'd2684354;
  localparam logic [31:0] RECIP_100  = 32'd20971;

  typedef struct packed {
    logic [9:0]         ratio;
    logic signed [13:0] level;
    logic [10:0]        decay;
  } bell_entry_t;

  // 440 Hz times 2^(k/12) in Q24
  function automatic logic [33:0] f440_lut(input logic [3:0] k);
    logic [33:0] v;
    case (k)
      4'd0:    v = 34'd7381975040;
      4'd1:    v = 34'd7820930040;
      4'd2:    v = 34'd8285986720;
      4'd3:    v = 34'd8778697400;
      4'd4:    v = 34'd9300705920;
      4'd5:    v = 34'd9853754680;
      4'd6:    v = 34'd10439689040;
      4'd7:    v = 34'd11060465240;
      4'd8:    v = 34'd11718154800;
      4'd9:    v = 34'd12414952880;
      4'd10:   v = 34'd13153184000;
      4'd11:   v = 34'd13935313040;
      default: v = 34'd7381975040;
    endcase
    return v;
  endfunction

  function automatic bell_entry_t bell_lookup(input logic bar, input logic [3:0] idx);
    bell_entry_t b;
    if (bar) begin
      case (idx)
        4'd0:    b = '{10'd100, 14'sd0, 11'd256};
        4'd1:    b = '{10'd276, -14'sd1792, 11'd410};
        4'd2:    b = '{10'd540, -14'sd3584, 11'd640};
        default: b = '{10'd893, -14'sd5376, 11'd922};
      endcase
    end else begin
      case (idx)
        4'd0:    b = '{10'd50, -14'sd768, 11'd128};
        4'd1:    b = '{10'd100, 14'sd0, 11'd179};
        4'd2:    b = '{10'd120, -14'sd512, 11'd256};
        4'd3:    b = '{10'd150, -14'sd2304, 11'd333};
        4'd4:    b = '{10'd200, -14'sd768, 11'd384};
        4'd5:    b = '{10'd250, -14'sd2048, 11'd461};
        4'd6:    b = '{10'd267, -14'sd3072, 11'd512};
        4'd7:    b = '{10'd300, -14'sd2816, 11'd589};
        4'd8:    b = '{10'd370, -14'sd3584, 11'd666};
        4'd9:    b = '{10'd420, -14'sd3840, 11'd768};
        4'd10:   b = '{10'd540, -14'sd4864, 11'd896};
        default: b = '{10'd680, -14'sd5888, 11'd1075};
      endcase
    end
    return b;
  endfunction

  // taylor series divisors, innermost first
  function automatic logic [31:0] sine_div(input logic [2:0] j);
    logic [31:0] d;
    case (j)
      3'd0:    d = 32'd110;
      3'd1:    d = 32'd72;
      3'd2:    d = 32'd42;
      3'd3:    d = 32'd20;
      default: d = 32'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] sine_recip(input logic [2:0] j);
    logic [31:0] r;
    case (j)
      3'd0:    r = 32'd39045157;
      3'd1:    r = 32'd59652323;
      3'd2:    r = 32'd102261126;
      3'd3:    r = 32'd214748364;
      default: r = 32'd715827882;
    endcase
    return r;
  endfunction

endpackage

/* rtl/additive_partial_generator_unit.sv */
// ----------------------------------------------------------------------------
// additive_partial_generator_unit
// one note in, a series of partials out, all arithmetic on one shared
// 32x32 multiplier and a bit-serial square root under a sequencer
// harmonic mode: per partial a 20-step square root, a 16-step log loop and,
// if comb depth is nonzero, a sine series and a second 16-step log loop; up to 64 partials
// bell modes: a multiply, a divide and a rounding fix per partial; not ready until the last partial is taken
// reset: synchronous, config registers, state and out_valid return to their reset values, block idles
// ----------------------------------------------------------------------------
module additive_partial_generator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [apg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [6:0]                       note_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      partial_freq,
  output logic signed [19:0]               partial_level,
  output logic [15:0]                      decay_factor,
  output logic [6:0]                       partial_number,
  output logic                             last_partial
);
  import apg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_BELL_MUL, S_BELL_DIV, S_BELL_FIX, S_NSQ, S_STIFF, S_SQRT,
    S_F0N, S_FLO, S_FHI, S_LNORM, S_LSQ, S_SLOPE, S_PH, S_Y, S_Y2, S_TMUL,
    S_DIV, S_DFIX, S_SFIN, S_COMB1, S_COMB2, S_DEC1, S_DEC2, S_DEC3, S_DEC4,
    S_OUT
  } state_t;

  logic [1:0]         partial_mode;
  logic [6:0]         partial_count;
  logic signed [13:0] slope_db_per_octave;
  logic [8:0]         even_cut;
  logic [17:0]        stiffness;
  logic [8:0]         comb_depth;
  logic [15:0]        comb_position;
  logic [8:0]         high_damping;

  state_t       state;
  logic [6:0]   n;
  logic [6:0]   last_n;
  logic [29:0]  f0;
  logic [35:0]  f0n;
  logic [52:0]  fr;
  logic [39:0]  sq_v;
  logic [39:0]  sq_r;
  logic [4:0]   sq_i;
  logic [31:0]  lg_m;
  logic [3:0]   lg_sh;
  logic [15:0]  lg_frac;
  logic [3:0]   lg_cnt;
  logic         lg_for_sine;
  logic signed [21:0] lvl;
  logic [15:0]  ph;
  logic [30:0]  y;
  logic [31:0]  y2;
  logic [30:0]  tv;
  logic [39:0]  dv;
  logic [31:0]  qv;
  logic [2:0]   dj;
  logic [31:0]  freq_r;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // helpers
  logic [7:0]  e_val;
  logic [14:0] e_mul;
  logic [3:0]  oct;
  logic [7:0]  semi_full;
  logic [43:0] f0_wide;
  logic [6:0]  cnt_clamped;
  logic [6:0]  bell_len;
  bell_entry_t bell;
  logic [39:0] sq_bit;
  logic [39:0] sq_sum;
  logic [32:0] lsq_m;
  logic [18:0] ln_val;
  logic [19:0] lmag;
  logic        slope_neg;
  logic [13:0] slope_mag;
  logic signed [34:0] sp_s;
  logic signed [34:0] sv;
  logic signed [34:0] st_full;
  logic [14:0] even_amt;
  logic signed [21:0] lvl_slope;
  logic signed [49:0] cbias;
  logic signed [49:0] ct_full;
  logic [15:0] ph_raw;
  logic [32:0] dfix_r;
  logic [31:0] dfix_q;
  logic [31:0] s_raw;
  logic [31:0] s_clamp;
  logic [59:0] f_total;
  logic [25:0] bell_r;
  logic [20:0] dec_r;
  logic [31:0] dec_q;
  logic [16:0] dec_sum;
  logic [19:0] lvl_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_mode        <= MODE_HARMONIC;
      partial_count       <= 7'd1;
      slope_db_per_octave <= '0;
      even_cut            <= '0;
      stiffness           <= '0;
      comb_depth          <= '0;
      comb_position       <= 16'd18350;
      high_damping        <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:  partial_mode        <= cfg_data[1:0];
        REG_COUNT: partial_count       <= cfg_data[6:0];
        REG_SLOPE: slope_db_per_octave <= $signed(cfg_data[13:0]);
        REG_EVEN:  even_cut            <= cfg_data[8:0];
        REG_STIFF: stiffness           <= cfg_data[17:0];
        REG_DEPTH: comb_depth          <= cfg_data[8:0];
        REG_POS:   comb_position       <= cfg_data[15:0];
        REG_DAMP:  high_damping        <= cfg_data[8:0];
        default:   ;
      endcase
    end
  end

  // equal tempered fundamental
  assign e_val     = {1'b0, note_number} + 8'd3;
  assign e_mul     = ({7'b0, e_val} << 7) + ({7'b0, e_val} << 5) + ({7'b0, e_val} << 3)
                   + ({7'b0, e_val} << 1) + {7'b0, e_val};
  assign oct       = e_mul[14:11];
  assign semi_full = e_val - ({4'b0, oct} << 3) - ({4'b0, oct} << 2);
  assign f0_wide   = ({10'b0, f440_lut(semi_full[3:0])} << oct) + 44'd8192;

  assign cnt_clamped = (partial_count == 7'd0) ? 7'd1 :
                       (partial_count > 7'(MAX_PARTIALS)) ? 7'(MAX_PARTIALS) : partial_count;
  assign bell_len    = (partial_mode == MODE_BAR) ?
                       ((7'd4 > 7'(MAX_PARTIALS)) ? 7'(MAX_PARTIALS) : 7'd4) :
                       ((7'd12 > 7'(MAX_PARTIALS)) ? 7'(MAX_PARTIALS) : 7'd12);
  assign bell        = bell_lookup(partial_mode == MODE_BAR, 4'(n - 7'd1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_BELL_MUL: begin mul_a = {2'b0, f0};         mul_b = {22'b0, bell.ratio}; end
      S_BELL_DIV: begin mul_a = {6'b0, dv[39:14]};  mul_b = RECIP_25;            end
      S_BELL_FIX: begin mul_a = qv;                 mul_b = 32'd25;              end
      S_NSQ:      begin mul_a = {25'b0, n};         mul_b = {25'b0, n};          end
      S_STIFF:    begin mul_a = {14'b0, stiffness}; mul_b = {19'b0, dv[12:0]};   end
      S_F0N:      begin mul_a = {2'b0, f0};         mul_b = {25'b0, n};          end
      S_FLO:      begin mul_a = f0n[31:0];          mul_b = {11'b0, sq_r[20:0]}; end
      S_FHI:      begin mul_a = {28'b0, f0n[35:32]}; mul_b = {11'b0, sq_r[20:0]}; end
      S_LSQ:      begin mul_a = lg_m;               mul_b = lg_m;                end
      S_SLOPE:    begin mul_a = {18'b0, slope_mag}; mul_b = {13'b0, ln_val};     end
      S_PH:       begin mul_a = {25'b0, n};         mul_b = {16'b0, comb_position}; end
      S_Y:        begin mul_a = {16'b0, ph};        mul_b = PI_Q30;              end
      S_Y2:       begin mul_a = {1'b0, y};          mul_b = {1'b0, y};           end
      S_TMUL:     begin mul_a = y2;                 mul_b = {1'b0, tv};          end
      S_DIV:      begin mul_a = dv[31:0];           mul_b = sine_recip(dj);      end
      S_DFIX:     begin mul_a = qv;                 mul_b = sine_div(dj);        end
      S_SFIN:     begin mul_a = {1'b0, y};          mul_b = {1'b0, tv};          end
      S_COMB1:    begin mul_a = {23'b0, comb_depth}; mul_b = {12'b0, lmag};      end
      S_COMB2:    begin mul_a = qv;                 mul_b = DB20_LOG2;           end
      S_DEC1:     begin mul_a = {23'b0, high_damping}; mul_b = {25'b0, n - 7'd1}; end
      S_DEC2:     begin mul_a = dv[31:0];           mul_b = 32'd35;              end
      S_DEC3:     begin mul_a = dv[31:0];           mul_b = RECIP_100;           end
      S_DEC4:     begin mul_a = qv;                 mul_b = 32'd100;             end
      default:    begin mul_a = '0;                 mul_b = '0;                  end
    endcase
  end

  assign prod = mul_a * mul_b;

  // square root step
  assign sq_bit = 40'd1 << (6'd38 - {sq_i, 1'b0});
  assign sq_sum = sq_r + sq_bit;

  // log squaring step
  assign lsq_m  = prod[62:30];
  assign ln_val = {3'd6 - lg_sh[2:0], lg_frac};
  assign lmag   = {lg_sh, 16'b0} - {4'b0, lg_frac};

  // slope and even terms
  assign slope_neg = slope_db_per_octave[13];
  assign slope_mag = slope_neg ? 14'(-slope_db_per_octave) : slope_db_per_octave;
  assign sp_s      = $signed({2'b0, prod[32:0]});
  assign sv        = slope_neg ? -sp_s : sp_s;
  assign st_full   = (sv + 35'sd32768) >>> 16;
  assign even_amt  = n[0] ? 15'd0 : ({6'b0, even_cut} << 5) + ({6'b0, even_cut} << 4);
  assign lvl_slope = st_full[21:0] - $signed({7'b0, even_amt});

  // comb term
  assign cbias   = 50'sh80000000 - $signed({2'b0, prod[47:0]});
  assign ct_full = cbias >>> 32;

  assign ph_raw  = prod[15:0];
  assign dfix_r  = {1'b0, dv[31:0]} - prod[32:0];
  assign dfix_q  = (dfix_r >= {1'b0, sine_div(dj)}) ? qv + 32'd1 : qv;
  assign s_raw   = prod[61:30];
  assign s_clamp = (s_raw < FLOOR_Q30) ? FLOOR_Q30 :
                   (s_raw > {1'b0, ONE_Q30}) ? {1'b0, ONE_Q30} : s_raw;

  assign f_total = {7'b0, fr} + {prod[27:0], 32'b0} + 60'h8000000;
  assign bell_r  = dv[39:14] - prod[25:0];
  assign dec_r   = dv[20:0] - prod[20:0];
  assign dec_q   = (dec_r >= 21'd100) ? qv + 32'd1 : qv;
  assign dec_sum = 17'd256 + dec_q[16:0];
  assign lvl_sat = (lvl > 22'sd524287) ? 20'h7FFFF :
                   (lvl < -22'sd524288) ? 20'h80000 : lvl[19:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            f0 <= f0_wide[43:14];
            n  <= 7'd1;
            if (partial_mode != MODE_HARMONIC) begin
              last_n <= bell_len;
              state  <= S_BELL_MUL;
            end else begin
              last_n <= cnt_clamped;
              state  <= S_NSQ;
            end
          end
        end
        S_BELL_MUL: begin
          dv    <= prod[39:0] + 40'd204800;
          state <= S_BELL_DIV;
        end
        S_BELL_DIV: begin
          qv    <= 32'(prod[63:26]);
          state <= S_BELL_FIX;
        end
        S_BELL_FIX: begin
          partial_freq   <= (bell_r >= 26'd25) ? qv + 32'd1 : qv;
          partial_level  <= 20'(bell.level);
          decay_factor   <= {5'b0, bell.decay};
          partial_number <= n;
          last_partial   <= (n == last_n);
          out_valid      <= 1'b1;
          state          <= S_OUT;
        end
        S_NSQ: begin
          dv    <= {27'b0, prod[12:0]};
          state <= S_STIFF;
        end
        S_STIFF: begin
          sq_v  <= {prod[31:0] + 32'h01000000, 8'b0};
          sq_r  <= '0;
          sq_i  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_v >= sq_sum) begin
            sq_v <= sq_v - sq_sum;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_i <= sq_i + 5'd1;
          if (sq_i == 5'd19) begin
            state <= S_F0N;
          end
        end
        S_F0N: begin
          f0n   <= prod[35:0];
          state <= S_FLO;
        end
        S_FLO: begin
          fr    <= prod[52:0];
          state <= S_FHI;
        end
        S_FHI: begin
          freq_r      <= f_total[59:28];
          lg_m        <= {1'b0, n, 24'b0};
          lg_sh       <= '0;
          lg_cnt      <= '0;
          lg_for_sine <= 1'b0;
          state       <= S_LNORM;
        end
        S_LNORM: begin
          if (lg_m[30]) begin
            state <= S_LSQ;
          end else begin
            lg_m  <= lg_m << 1;
            lg_sh <= lg_sh + 4'd1;
          end
        end
        S_LSQ: begin
          lg_frac <= {lg_frac[14:0], lsq_m[31]};
          lg_m    <= lsq_m[31] ? lsq_m[32:1] : lsq_m[31:0];
          lg_cnt  <= lg_cnt + 4'd1;
          if (lg_cnt == 4'd15) begin
            state <= lg_for_sine ? S_COMB1 : S_SLOPE;
          end
        end
        S_SLOPE: begin
          lvl   <= lvl_slope;
          state <= (comb_depth != 9'd0) ? S_PH : S_DEC1;
        end
        S_PH: begin
          ph    <= (ph_raw > 16'd32768) ? 16'(17'd65536 - {1'b0, ph_raw}) : ph_raw;
          state <= S_Y;
        end
        S_Y: begin
          y     <= prod[46:16];
          state <= S_Y2;
        end
        S_Y2: begin
          y2    <= prod[61:30];
          dv    <= {8'b0, prod[61:30]};
          dj    <= '0;
          state <= S_DIV;
        end
        S_TMUL: begin
          dv    <= {8'b0, prod[61:30]};
          state <= S_DIV;
        end
        S_DIV: begin
          qv    <= prod[63:32];
          state <= S_DFIX;
        end
        S_DFIX: begin
          tv <= ONE_Q30 - dfix_q[30:0];
          if (dj == 3'd4) begin
            state <= S_SFIN;
          end else begin
            dj    <= dj + 3'd1;
            state <= S_TMUL;
          end
        end
        S_SFIN: begin
          lg_m        <= s_clamp;
          lg_sh       <= '0;
          lg_cnt      <= '0;
          lg_for_sine <= 1'b1;
          state       <= S_LNORM;
        end
        S_COMB1: begin
          qv    <= prod[31:0];
          state <= S_COMB2;
        end
        S_COMB2: begin
          lvl   <= lvl + ct_full[21:0];
          state <= S_DEC1;
        end
        S_DEC1: begin
          dv    <= {24'b0, prod[15:0]};
          state <= S_DEC2;
        end
        S_DEC2: begin
          dv    <= {19'b0, prod[20:0] + 21'd50};
          state <= S_DEC3;
        end
        S_DEC3: begin
          qv    <= 32'(prod[63:21]);
          state <= S_DEC4;
        end
        S_DEC4: begin
          partial_freq   <= freq_r;
          partial_level  <= lvl_sat;
          decay_factor   <= dec_sum[16] ? 16'hFFFF : dec_sum[15:0];
          partial_number <= n;
          last_partial   <= (n == last_n);
          out_valid      <= 1'b1;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_partial) begin
              state <= S_IDLE;
            end else begin
              n     <= n + 7'd1;
              state <= (partial_mode != MODE_HARMONIC) ? S_BELL_MUL : S_NSQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/apg_checker.sv */
// ----------------------------------------------------------------------------
// apg_checker
// port level checks of the additive partial generator, bound to the top level
// ----------------------------------------------------------------------------
`include "additive_partial_generator_unit_macros.svh"

module apg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] partial_freq,
  input logic [6:0]  partial_number,
  input logic        last_partial
);

  `APG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `APG_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(partial_freq) && $stable(partial_number))
  `APG_ASSERT_NOW(a_idle_empty, !in_stall, !out_valid)
  `APG_ASSERT_NEXT(a_series_busy, out_valid && !out_stall && !last_partial, in_stall && !out_valid)
  `APG_ASSERT_NEXT(a_request_busy, in_valid && !in_stall, in_stall)

endmodule

bind additive_partial_generator_unit apg_checker u_apg_checker (.*);
